>>> sv/protobuf_top_level_field_sniffer_macros.svh
// ----------------------------------------------------------------------------
// Field sniffer assertion macros
// Shared concurrent check shorthands; both expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef PROTOBUF_TOP_LEVEL_FIELD_SNIFFER_MACROS_SVH
`define PROTOBUF_TOP_LEVEL_FIELD_SNIFFER_MACROS_SVH

// same-cycle implication
`define PBFS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PBFS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/pbfs_pkg.sv
// ----------------------------------------------------------------------------
// Field sniffer package
// Item types, verdict cause codes and defaults shared by the sniffer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pbfs_pkg;

    localparam int DEF_MAX_VARINT_BYTES = 10;
    localparam logic [7:0] DEF_FIELD_LIMIT = 8'd12;

    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;
    localparam int VALUE_W = 64;

    // register index (byte address / 4)
    localparam logic REG_FIELD_LIMIT = 1'b0;

    // verdict causes
    localparam logic [2:0] C_FIELD1  = 3'd0;
    localparam logic [2:0] C_PAYLOAD = 3'd1;
    localparam logic [2:0] C_TRUNC   = 3'd2;
    localparam logic [2:0] C_WIRE    = 3'd3;
    localparam logic [2:0] C_ZERO    = 3'd4;
    localparam logic [2:0] C_LONG    = 3'd5;
    localparam logic [2:0] C_LIMIT   = 3'd6;
    localparam logic [2:0] C_CLEAN   = 3'd7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic       accepted;
        logic [2:0] cause;
        logic [7:0] fields_seen;
    } out_item_t;

    typedef struct packed {
        logic      hit;
        out_item_t item;
    } pbfs_verdict_t;

endpackage

`default_nettype wire

>>> sv/pbfs_scan.sv
// ----------------------------------------------------------------------------
// Field sniffer scan core
// Per-file scanner state and the one-byte update of tag, value and skip.
// ----------------------------------------------------------------------------
`default_nettype none

`include "protobuf_top_level_field_sniffer_macros.svh"

module pbfs_scan
    import pbfs_pkg::*;
#(
    parameter int MAX_VARINT_BYTES = DEF_MAX_VARINT_BYTES
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          take,
    input  wire in_item_t      item,
    input  wire logic [7:0]    field_limit,
    output pbfs_verdict_t      verdict
);

    localparam int VB_W = $clog2(MAX_VARINT_BYTES);

    localparam logic [2:0] PH_TAG          = 3'd0;
    localparam logic [2:0] PH_VALUE        = 3'd1;
    localparam logic [2:0] PH_LEN          = 3'd2;
    localparam logic [2:0] PH_SKIP_FIXED   = 3'd3;
    localparam logic [2:0] PH_SKIP_PAYLOAD = 3'd4;

    localparam logic [2:0] WT_VARINT = 3'd0;
    localparam logic [2:0] WT_I64    = 3'd1;
    localparam logic [2:0] WT_LEN    = 3'd2;
    localparam logic [2:0] WT_I32    = 3'd5;

    localparam logic [31:0] FN_VARINT_HIT = 32'd1;
    localparam logic [31:0] FN_PAYLOAD_A  = 32'd7;
    localparam logic [31:0] FN_PAYLOAD_B  = 32'd8;

    logic [2:0]         phase_reg,    phase_next;
    logic [VB_W-1:0]    vb_reg,       vb_next;
    logic [VALUE_W-1:0] value_reg,    value_next;
    logic [31:0]        fn_reg,       fn_next;
    logic [VALUE_W-1:0] rem_reg,      rem_next;
    logic [7:0]         count_reg,    count_next;
    logic               decided_reg,  decided_next;

    logic [7:0]         cnt_inc;
    logic [7:0]         lim;
    logic [VALUE_W-1:0] value_acc;
    logic [VALUE_W-1:0] rem_dec;
    logic [VB_W:0]      vb_inc;
    logic               dec;
    logic               acc;
    logic [2:0]         cause;

    always_comb
    begin
        phase_next   = phase_reg;
        vb_next      = vb_reg;
        value_next   = value_reg;
        fn_next      = fn_reg;
        rem_next     = rem_reg;
        count_next   = count_reg;
        decided_next = decided_reg;
        dec          = 1'b0;
        acc          = 1'b0;
        cause        = C_CLEAN;

        // a new field starts on the first byte of a tag
        cnt_inc = count_reg;
        if (phase_reg == PH_TAG && vb_reg == '0 && count_reg != 8'hFF)
        begin
            cnt_inc = count_reg + 8'd1;
        end
        lim = (field_limit == 8'd0) ? 8'd1 : field_limit;

        value_acc = value_reg;
        for (int k = 0; k < MAX_VARINT_BYTES; k++)
        begin
            if (vb_reg == VB_W'(k))
            begin
                value_acc = value_reg | (VALUE_W'(item.data_byte[6:0]) << (7 * k));
            end
        end
        vb_inc  = {1'b0, vb_reg} + 1'b1;
        rem_dec = (rem_reg == '0) ? '0 : rem_reg - 1'b1;

        if (take && !decided_reg)
        begin
            count_next = cnt_inc;
            if (phase_reg == PH_SKIP_FIXED || phase_reg == PH_SKIP_PAYLOAD)
            begin
                rem_next = rem_dec;
                if (rem_dec == '0)
                begin
                    if (phase_reg == PH_SKIP_PAYLOAD &&
                        (fn_reg == FN_PAYLOAD_A || fn_reg == FN_PAYLOAD_B))
                    begin
                        dec   = 1'b1;
                        acc   = 1'b1;
                        cause = C_PAYLOAD;
                    end
                    else
                    begin
                        phase_next = PH_TAG;
                        if (cnt_inc >= lim)
                        begin
                            dec   = 1'b1;
                            cause = C_LIMIT;
                        end
                    end
                end
            end
            else if (item.data_byte[7])
            begin
                value_next = value_acc;
                vb_next    = vb_inc[VB_W-1:0];
                if (vb_inc >= (VB_W+1)'(MAX_VARINT_BYTES))
                begin
                    dec   = 1'b1;
                    cause = C_LONG;
                end
            end
            else
            begin
                // varint complete
                value_next = '0;
                vb_next    = '0;
                unique case (phase_reg)
                    PH_TAG:
                    begin
                        fn_next = value_acc[34:3];
                        if (value_acc[34:3] == 32'd0)
                        begin
                            dec   = 1'b1;
                            cause = C_ZERO;
                        end
                        else
                        begin
                            case (value_acc[2:0])
                                WT_VARINT: phase_next = PH_VALUE;
                                WT_I64:
                                begin
                                    rem_next   = VALUE_W'(8);
                                    phase_next = PH_SKIP_FIXED;
                                end
                                WT_LEN:    phase_next = PH_LEN;
                                WT_I32:
                                begin
                                    rem_next   = VALUE_W'(4);
                                    phase_next = PH_SKIP_FIXED;
                                end
                                default:
                                begin
                                    dec   = 1'b1;
                                    cause = C_WIRE;
                                end
                            endcase
                        end
                    end
                    PH_VALUE:
                    begin
                        if (fn_reg == FN_VARINT_HIT)
                        begin
                            dec   = 1'b1;
                            acc   = 1'b1;
                            cause = C_FIELD1;
                        end
                        else
                        begin
                            phase_next = PH_TAG;
                            if (cnt_inc >= lim)
                            begin
                                dec   = 1'b1;
                                cause = C_LIMIT;
                            end
                        end
                    end
                    default:
                    begin
                        // length varint
                        if (value_acc == '0)
                        begin
                            if (fn_reg == FN_PAYLOAD_A || fn_reg == FN_PAYLOAD_B)
                            begin
                                dec   = 1'b1;
                                acc   = 1'b1;
                                cause = C_PAYLOAD;
                            end
                            else
                            begin
                                phase_next = PH_TAG;
                                if (cnt_inc >= lim)
                                begin
                                    dec   = 1'b1;
                                    cause = C_LIMIT;
                                end
                            end
                        end
                        else
                        begin
                            rem_next   = value_acc;
                            phase_next = PH_SKIP_PAYLOAD;
                        end
                    end
                endcase
            end

            // end of file without an earlier verdict
            if (!dec && item.last_byte)
            begin
                dec   = 1'b1;
                cause = (phase_next == PH_TAG && vb_next == '0) ? C_CLEAN : C_TRUNC;
            end
            decided_next = dec;
        end

        // last byte rearms for the next file
        if (take && item.last_byte)
        begin
            phase_next   = PH_TAG;
            vb_next      = '0;
            value_next   = '0;
            fn_next      = '0;
            rem_next     = '0;
            count_next   = '0;
            decided_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_TAG;
            vb_reg      <= '0;
            value_reg   <= '0;
            fn_reg      <= '0;
            rem_reg     <= '0;
            count_reg   <= '0;
            decided_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            vb_reg      <= vb_next;
            value_reg   <= value_next;
            fn_reg      <= fn_next;
            rem_reg     <= rem_next;
            count_reg   <= count_next;
            decided_reg <= decided_next;
        end
    end

    assign verdict.hit              = take && !decided_reg && dec;
    assign verdict.item.accepted    = acc;
    assign verdict.item.cause       = cause;
    assign verdict.item.fields_seen = (cnt_inc > field_limit) ? field_limit : cnt_inc;

    `PBFS_ASSERT_NEXT(a_last_rearms, take && item.last_byte,
        phase_reg == PH_TAG && count_reg == 8'd0 && !decided_reg, "last byte did not rearm")
    `PBFS_ASSERT_NOW(a_vb_bound, !decided_reg,
        {1'b0, vb_reg} < (VB_W+1)'(MAX_VARINT_BYTES), "varint byte count overran")
    `PBFS_ASSERT_NOW(a_skip_live,
        !decided_reg && (phase_reg == PH_SKIP_FIXED || phase_reg == PH_SKIP_PAYLOAD),
        rem_reg != '0, "skip phase with nothing left to skip")

endmodule

`default_nettype wire

>>> sv/protobuf_top_level_field_sniffer.sv
// ----------------------------------------------------------------------------
// Protobuf top-level field sniffer
// Throughput: one byte item per cycle, back to back, while the verdict register is empty or draining.
// The verdict is registered: it is in the output register in the cycle after its byte is taken.
// Reset: field_limit returns to 12 and the scanner to the start of a tag.
// ----------------------------------------------------------------------------
`default_nettype none

`include "protobuf_top_level_field_sniffer_macros.svh"

// The scan core updates its per-file state combinationally from each accepted
// byte; at most one verdict per file lands in a single output register. The
// input side stays ready whenever that register is empty or being drained, so
// a byte per cycle flows as long as the consumer keeps up.
module protobuf_top_level_field_sniffer
    import pbfs_pkg::*;
#(
    parameter int MAX_VARINT_BYTES = DEF_MAX_VARINT_BYTES
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready,
    // byte stream
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire in_item_t          item,
    // verdicts
    output logic                   verdict_valid,
    input  wire logic              verdict_ready,
    output out_item_t              verdict
);

    logic          cfg_wr;
    logic [7:0]    field_limit_reg, field_limit_next;
    logic          take;
    pbfs_verdict_t scan_verdict;
    logic          out_valid_reg, out_valid_next;
    out_item_t     out_item_reg,  out_item_next;

    // ---- configuration register ------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        field_limit_next = field_limit_reg;
        if (cfg_wr && paddr[2] == REG_FIELD_LIMIT)
        begin
            field_limit_next = pwdata[7:0];
        end
    end

    // only one register; the low address bits are byte lanes
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_FIELD_LIMIT)
        begin
            prdata = DATA_W'(field_limit_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_limit_reg <= DEF_FIELD_LIMIT;
        end
        else
        begin
            field_limit_reg <= field_limit_next;
        end
    end

    // ---- scanner ---------------------------------------------------------
    // Accept whenever the output register has room after this edge.
    assign item_ready = !out_valid_reg || verdict_ready;
    assign take       = item_valid && item_ready;

    pbfs_scan #(
        .MAX_VARINT_BYTES (MAX_VARINT_BYTES)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .item        (item),
        .field_limit (field_limit_reg),
        .verdict     (scan_verdict)
    );

    // ---- output register -------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (verdict_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (scan_verdict.hit)
        begin
            out_valid_next = 1'b1;
            out_item_next  = scan_verdict.item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign verdict_valid = out_valid_reg;
    assign verdict       = out_item_reg;

    `PBFS_ASSERT_NEXT(a_hit_lands, scan_verdict.hit, out_valid_reg,
        "verdict not registered")
    `PBFS_ASSERT_NOW(a_accept_cause, out_valid_reg && out_item_reg.accepted,
        out_item_reg.cause == C_FIELD1 || out_item_reg.cause == C_PAYLOAD,
        "accept with a reject cause")
    `PBFS_ASSERT_NEXT(a_cfg_write, cfg_wr && paddr[2] == REG_FIELD_LIMIT,
        field_limit_reg == $past(pwdata[7:0]), "field_limit write lost")

endmodule

`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Protobuf field sniffer testbench
// Streams files byte by byte through the sniffer and checks every verdict
// against an in-bench scanner. The stimulus mixes directed files, well-formed
// field sequences with random content, broken endings and noise, under
// several field limits, random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
    import pbfs_pkg::*;

    localparam int VARINT_MAX = DEF_MAX_VARINT_BYTES;
    localparam logic [ADDR_W-1:0] LIMIT_ADDR = ADDR_W'(REG_FIELD_LIMIT) << 2;

    // protobuf wire types
    localparam logic [2:0] WT_VARINT = 3'd0;
    localparam logic [2:0] WT_I64    = 3'd1;
    localparam logic [2:0] WT_LEN    = 3'd2;
    localparam logic [2:0] WT_SGROUP = 3'd3;
    localparam logic [2:0] WT_EGROUP = 3'd4;
    localparam logic [2:0] WT_I32    = 3'd5;
    localparam logic [2:0] WT_RSVD6  = 3'd6;
    localparam logic [2:0] WT_RSVD7  = 3'd7;

    typedef enum logic [2:0] {
        SCAN_TAG,
        SCAN_VALUE,
        SCAN_LEN,
        SCAN_FIXED,
        SCAN_PAYLOAD
    } scan_state_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              item_valid = 1'b0;
    logic              item_ready;
    in_item_t          item = '0;
    logic              verdict_valid;
    logic              verdict_ready = 1'b0;
    out_item_t         verdict;

    protobuf_top_level_field_sniffer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .item          (item),
        .verdict_valid (verdict_valid),
        .verdict_ready (verdict_ready),
        .verdict       (verdict)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Scanner state mirrored in the bench. Only touched when a byte is
    // accepted, or by a limit write while the block is idle.
    // ------------------------------------------------------------------------
    logic [7:0]  model_limit = DEF_FIELD_LIMIT;
    scan_state_t scan_state;
    logic [3:0]  sc_vbytes;
    logic [63:0] sc_vval;
    logic [31:0] sc_fnum;
    logic [63:0] sc_skip;
    logic [7:0]  sc_count;
    bit          sc_done;
    bit          sc_acc;
    logic [2:0]  sc_cause;

    out_item_t   pending_verdicts[$];
    in_item_t    byte_queue[$];
    logic [7:0]  file_bytes[$];

    // bookkeeping
    int          errors = 0;
    int          files_queued = 0;
    int          items_queued = 0;
    int          verdicts_checked = 0;
    int          accepts_seen = 0;
    int          input_stalls = 0;
    logic [7:0]  causes_seen = '0;
    bit          byte_taken = 1'b0;
    int          hold_off = 0;

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 40)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic void clear_scan();
        scan_state = SCAN_TAG;
        sc_vbytes  = '0;
        sc_vval    = '0;
        sc_fnum    = '0;
        sc_skip    = '0;
        sc_count   = '0;
        sc_done    = 1'b0;
        sc_acc     = 1'b0;
        sc_cause   = '0;
    endfunction

    function automatic void close_verdict(input bit acc, input logic [2:0] cause);
        sc_done  = 1'b1;
        sc_acc   = acc;
        sc_cause = cause;
    endfunction

    // a field ended with no accept; a limit of zero would act as one
    function automatic void end_field();
        logic [7:0] lim;
        lim = (model_limit == 0) ? 8'd1 : model_limit;
        scan_state = SCAN_TAG;
        if (sc_count >= lim)
            close_verdict(1'b0, C_LIMIT);
    endfunction

    function automatic void end_payload();
        if (sc_fnum == 32'd7 || sc_fnum == 32'd8)
            close_verdict(1'b1, C_PAYLOAD);
        else
            end_field();
    endfunction

    // Advances the scanner by one accepted byte and queues the verdict it
    // decides, if any.
    task automatic sniff_byte(input in_item_t it);
        logic [63:0] v;
        int          sh;
        if (!sc_done)
        begin
            if (scan_state == SCAN_TAG && sc_vbytes == 0 && sc_count != 8'd255)
                sc_count++;
            if (scan_state == SCAN_FIXED || scan_state == SCAN_PAYLOAD)
            begin
                if (sc_skip != 0)
                    sc_skip--;
                if (sc_skip == 0)
                begin
                    if (scan_state == SCAN_PAYLOAD)
                        end_payload();
                    else
                        end_field();
                end
            end
            else
            begin
                sh = 7 * sc_vbytes;
                if (sh < 64)
                    sc_vval |= 64'(it.data_byte[6:0]) << sh;
                if (it.data_byte[7])
                begin
                    sc_vbytes++;
                    if (sc_vbytes >= VARINT_MAX)
                        close_verdict(1'b0, C_LONG);
                end
                else
                begin
                    v = sc_vval;
                    sc_vval = '0;
                    sc_vbytes = '0;
                    if (scan_state == SCAN_TAG)
                    begin
                        // field number keeps only 32 bits of tag >> 3
                        sc_fnum = v[34:3];
                        if (sc_fnum == 0)
                            close_verdict(1'b0, C_ZERO);
                        else
                        begin
                            case (v[2:0])
                                WT_VARINT: scan_state = SCAN_VALUE;
                                WT_I64:
                                begin
                                    sc_skip = 64'd8;
                                    scan_state = SCAN_FIXED;
                                end
                                WT_LEN: scan_state = SCAN_LEN;
                                WT_I32:
                                begin
                                    sc_skip = 64'd4;
                                    scan_state = SCAN_FIXED;
                                end
                                default: close_verdict(1'b0, C_WIRE);
                            endcase
                        end
                    end
                    else if (scan_state == SCAN_VALUE)
                    begin
                        if (sc_fnum == 32'd1)
                            close_verdict(1'b1, C_FIELD1);
                        else
                            end_field();
                    end
                    else if (v == 0)
                        end_payload();
                    else
                    begin
                        sc_skip = v;
                        scan_state = SCAN_PAYLOAD;
                    end
                end
            end
            // end of file: boundary is a clean end, anything else truncated
            if (!sc_done && it.last_byte)
                close_verdict(1'b0, (scan_state == SCAN_TAG && sc_vbytes == 0) ?
                              C_CLEAN : C_TRUNC);
            if (sc_done)
                pending_verdicts.push_back('{accepted: sc_acc, cause: sc_cause,
                    fields_seen: (sc_count > model_limit) ? model_limit : sc_count});
        end
        if (it.last_byte)
            clear_scan();
    endtask

    // ------------------------------------------------------------------------
    // Monitor: checks verdicts and feeds accepted bytes to the scanner.
    // Sampled at the rising edge; inputs only move on the falling edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : verdict_monitor
        out_item_t want;
        if (rst_n)
        begin
            if (verdict_valid && verdict_ready)
            begin
                if (pending_verdicts.size() == 0)
                    report_mismatch($sformatf("unexpected verdict %p", verdict));
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (verdict.accepted !== want.accepted)
                        report_mismatch($sformatf("accepted %b, want %b",
                                        verdict.accepted, want.accepted));
                    if (verdict.cause !== want.cause)
                        report_mismatch($sformatf("cause %0d, want %0d",
                                        verdict.cause, want.cause));
                    if (verdict.fields_seen !== want.fields_seen)
                        report_mismatch($sformatf("fields_seen %0d, want %0d",
                                        verdict.fields_seen, want.fields_seen));
                    verdicts_checked++;
                    if (want.accepted)
                        accepts_seen++;
                    causes_seen[want.cause] = 1'b1;
                end
            end
            if (item_valid && !item_ready)
                input_stalls++;
            byte_taken = item_valid && item_ready;
            if (byte_taken)
                sniff_byte(item);
        end
    end

    // ------------------------------------------------------------------------
    // Driver: bursts of bytes from byte_queue with random gaps in between.
    // Valid holds with a steady payload until the byte is taken.
    // ------------------------------------------------------------------------
    int burst_left = 0;
    int gap_left = 0;

    always @(negedge clk)
    begin : byte_driver
        logic     nv;
        in_item_t np;
        nv = item_valid;
        np = item;
        if (nv && byte_taken)
            nv = 1'b0;
        if (rst_n && !nv)
        begin
            if (gap_left > 0)
                gap_left--;
            else if (byte_queue.size() > 0)
            begin
                np = byte_queue.pop_front();
                nv = 1'b1;
                if (burst_left > 1)
                    burst_left--;
                else if ($urandom_range(0, 4) == 0)
                begin
                    // long stretch with no idling
                    burst_left = $urandom_range(60, 150);
                    gap_left = 0;
                end
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = $urandom_range(1, 7);
                end
            end
        end
        item_valid <= nv;
        item <= np;
    end

    // ------------------------------------------------------------------------
    // Receiver: rotates a random stall pattern, swapped for a new one when pattern_age runs out.
    // hold_off forces a long stall so the output register backs up.
    // ------------------------------------------------------------------------
    logic [15:0] stall_pattern = 16'hFFFF;
    int          pattern_age = 0;

    always @(negedge clk)
    begin : verdict_receiver
        if (hold_off > 0)
        begin
            hold_off--;
            verdict_ready <= 1'b0;
        end
        else
        begin
            if (pattern_age == 0)
            begin
                stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom) | 16'h1;
                pattern_age = 200;
            end
            pattern_age--;
            stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
            verdict_ready <= stall_pattern[0];
        end
    end

    // ------------------------------------------------------------------------
    // Configuration access: setup cycle, then access cycle.
    // ------------------------------------------------------------------------
    task automatic apb_cycle(input bit wr, input logic [ADDR_W-1:0] a,
                             input logic [DATA_W-1:0] d, output logic [DATA_W-1:0] rd);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= a;
        pwdata <= d;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rd = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic check_limit_reg(input logic [7:0] want);
        logic [DATA_W-1:0] rd;
        apb_cycle(1'b0, LIMIT_ADDR, '0, rd);
        if (rd[7:0] !== want)
            report_mismatch($sformatf("field_limit reads %0d, want %0d", rd[7:0], want));
    endtask

    task automatic set_field_limit(input logic [7:0] lim);
        logic [DATA_W-1:0] rd;
        apb_cycle(1'b1, LIMIT_ADDR, DATA_W'(lim), rd);
        model_limit = lim;
        check_limit_reg(lim);
    endtask

    // sender pause: nothing queued, nothing in flight, every verdict back
    task automatic wait_idle();
        while (byte_queue.size() != 0 || item_valid || pending_verdicts.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // File building
    // ------------------------------------------------------------------------
    task automatic queue_file();
        in_item_t it;
        if (file_bytes.size() == 0)
            file_bytes.push_back(8'($urandom));
        foreach (file_bytes[i])
        begin
            it.data_byte = file_bytes[i];
            it.last_byte = (i == file_bytes.size() - 1);
            byte_queue.push_back(it);
        end
        files_queued++;
        items_queued += file_bytes.size();
        file_bytes.delete();
    endtask

    function automatic logic [63:0] rand_wide();
        return {$urandom, $urandom} >> $urandom_range(0, 63);
    endfunction

    // occasional redundant continuation bytes, still within ten bytes
    function automatic int rand_pad();
        return ($urandom_range(0, 6) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    task automatic put_varint(input logic [63:0] v, input int pad);
        int          n;
        logic [63:0] rest;
        n = 1;
        rest = v >> 7;
        while (rest != 0)
        begin
            n++;
            rest = rest >> 7;
        end
        n = (n + pad > VARINT_MAX) ? VARINT_MAX : n + pad;
        for (int i = 0; i < n; i++)
            file_bytes.push_back({(i < n - 1) ? 1'b1 : 1'b0, 7'(v >> (7 * i))});
    endtask

    function automatic logic [63:0] rand_field_num();
        case ($urandom_range(0, 9))
            0: return (rand_wide() >> 3) | 64'd1;
            1: return 64'd1;
            2: return 64'($urandom_range(7, 8));
            default: return 64'($urandom_range(2, 40));
        endcase
    endfunction

    task automatic put_field(input logic [63:0] fnum, input logic [2:0] wt);
        int n;
        put_varint({fnum[60:0], wt}, rand_pad());
        case (wt)
            WT_VARINT: put_varint(rand_wide(), rand_pad());
            WT_I64: repeat (8) file_bytes.push_back(8'($urandom));
            WT_I32: repeat (4) file_bytes.push_back(8'($urandom));
            WT_LEN:
            begin
                n = $urandom_range(0, 5);
                put_varint(64'(n), rand_pad());
                repeat (n) file_bytes.push_back(8'($urandom));
            end
            default: ;
        endcase
    endtask

    // Mostly well-formed field runs with a random ending; some pure noise.
    task automatic make_file();
        logic [2:0]  good_wt[4];
        logic [2:0]  bad_wt[4];
        logic [31:0] t;
        int          r;
        int          max_fields;
        good_wt = '{WT_VARINT, WT_I64, WT_LEN, WT_I32};
        bad_wt = '{WT_SGROUP, WT_EGROUP, WT_RSVD6, WT_RSVD7};
        max_fields = (model_limit < 14) ? model_limit + 2 : 14;
        if ($urandom_range(0, 99) < 6)
            repeat ($urandom_range(1, 12)) file_bytes.push_back(8'($urandom));
        else
        begin
            repeat ($urandom_range(0, max_fields))
                put_field(rand_field_num(), good_wt[$urandom_range(0, 3)]);
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                // overlong varint as tag, value or length
                if ($urandom_range(0, 1))
                    put_varint({rand_field_num() << 3} | 64'($urandom_range(0, 1) ? WT_VARINT
                               : WT_LEN), 0);
                repeat (VARINT_MAX) file_bytes.push_back(8'($urandom) | 8'h80);
            end
            else if (r < 18)
                put_varint({rand_field_num() << 3} | 64'(bad_wt[$urandom_range(0, 3)]),
                           rand_pad());
            else if (r < 24)
            begin
                // field zero, either plainly or hidden above bit 34 of the tag
                t = $urandom;
                put_varint($urandom_range(0, 1) ? {t[28:0], 32'h0, 3'(t)} : 64'(t[2:0]),
                           rand_pad());
            end
            else if (r < 34)
            begin
                if ($urandom_range(0, 1))
                    put_field(64'd1, WT_VARINT);
                else
                    put_field(64'($urandom_range(7, 8)), WT_LEN);
                repeat ($urandom_range(0, 4)) file_bytes.push_back(8'($urandom));
            end
            else if (r < 40)
            begin
                // length far beyond what the file holds
                put_varint({rand_field_num() << 3} | 64'(WT_LEN), 0);
                put_varint(rand_wide() | 64'h100, 0);
                repeat ($urandom_range(0, 6)) file_bytes.push_back(8'($urandom));
            end
            else if (r < 52 && file_bytes.size() > 1)
                repeat ($urandom_range(1, (file_bytes.size() > 4) ? 4 : file_bytes.size() - 1))
                    void'(file_bytes.pop_back());
        end
        queue_file();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_seq
        logic [7:0] limit_plan[6];
        int         phase_items;
        int         n;
        clear_scan();
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        check_limit_reg(DEF_FIELD_LIMIT);

        // directed files under the reset limit
        file_bytes = '{8'h08, 8'h96, 8'h01, 8'hFF};  // field 1 varint, then ignored byte
        queue_file();
        file_bytes = '{8'h3A, 8'h02, 8'h00, 8'hFF};  // field 7 payload ends on last byte
        queue_file();
        file_bytes = '{8'h42, 8'h00};                // field 8, empty payload
        queue_file();
        file_bytes = '{8'h00};                       // field zero
        queue_file();
        file_bytes = '{8'h0B};                       // start group wire type
        queue_file();
        file_bytes = '{8'h10};                       // ends inside a field
        queue_file();
        file_bytes = '{8'h10, 8'h05};                // ends at a field boundary
        queue_file();
        repeat (VARINT_MAX) file_bytes.push_back(8'hFF);  // overlong, flagged on last byte
        queue_file();
        wait_idle();

        limit_plan = '{8'd1, 8'd255, 8'd3, 8'($urandom_range(4, 254)), 8'd12, 8'd2};
        foreach (limit_plan[p])
        begin
            wait_idle();
            set_field_limit(limit_plan[p]);
            phase_items = items_queued;
            if (p == 2)
            begin
                // receiver holds off while one-byte files keep coming
                @(posedge clk);
                hold_off = 120;
                repeat (24)
                begin
                    file_bytes.push_back(8'($urandom));
                    queue_file();
                end
            end
            while (items_queued - phase_items < 95)
                make_file();
        end

        while (byte_queue.size() != 0 || item_valid)
            @(negedge clk);
        n = 0;
        while (pending_verdicts.size() != 0 && n < 5000)
        begin
            @(negedge clk);
            n++;
        end
        repeat (4) @(negedge clk);
        if (pending_verdicts.size() != 0)
            report_mismatch($sformatf("%0d verdicts never arrived", pending_verdicts.size()));

        $display("run: %0d bytes in %0d files, %0d verdicts checked, %0d accepts",
                 items_queued, files_queued, verdicts_checked, accepts_seen);
        $display("run: causes seen %b, %0d cycles with the input held off",
                 causes_seen, input_stalls);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // hard stop well past the slowest legal run
    initial
    begin : watchdog
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
